FILE: rtl/uapq_pkg.sv
// Shared constants, command and status codes, and controller/datapath
// structs for the unsorted-array priority queue. No dependencies.
`default_nettype none

package uapq_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int VAL_W  = 32;
    localparam int WORD_W = 2 * VAL_W;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MODIFY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // Value returned when there is no entry to report
    localparam logic [VAL_W-1:0] NONE_VALUE = '1;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              do_insert;
        logic              do_clear;
        logic              do_modify;
        logic              dec_count;
        logic              walk_start_scan;
        logic              walk_start_shift;
        logic              walk_scan;
        logic              walk_shift;
        logic              take_best;
        logic              set_status;
        logic [STAT_W-1:0] status_code;
        logic              finish;
    } uapq_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             count_zero;
        logic             count_full;
        logic             walk_done;
        logic             found;
        logic             shift_needed;
        logic             out_free;
    } uapq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/uapq_req_if.sv
// Request channel: one queue command word with valid/ready handshake.
// Depends on uapq_pkg for field widths.
`default_nettype none

interface uapq_req_if;
    logic                               valid;
    logic                               ready;
    logic [uapq_pkg::CMD_W-1:0]         cmd;
    logic signed [uapq_pkg::VAL_W-1:0]  item_value;
    logic signed [uapq_pkg::VAL_W-1:0]  item_priority;

    modport source (output valid, cmd, item_value, item_priority, input ready);
    modport sink   (input valid, cmd, item_value, item_priority, output ready);
endinterface

`default_nettype wire

FILE: rtl/uapq_rsp_if.sv
// Response channel: one result word per command with valid/ready handshake.
// Depends on uapq_pkg for field widths.
`default_nettype none

interface uapq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [uapq_pkg::VAL_W-1:0]  out_value;
    logic [uapq_pkg::STAT_W-1:0]        status;
    logic [uapq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, out_value, status, occupancy, input ready);
    modport sink   (input valid, out_value, status, occupancy, output ready);
endinterface

`default_nettype wire

FILE: rtl/uapq_ctrl.sv
// Command sequencer for the priority queue: dispatch, scan, shift, finish.
// Depends on uapq_pkg; drives uapq_datapath through uapq_ctrl_t.
`default_nettype none

module uapq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire uapq_pkg::uapq_stat_t sts,
    output uapq_pkg::uapq_ctrl_t      ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                case (sts.cmd)
                    uapq_pkg::CMD_INSERT:
                    begin
                        if (sts.count_full)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = uapq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.do_insert = 1'b1;
                        end
                    end
                    uapq_pkg::CMD_EXTRACT, uapq_pkg::CMD_PEEK:
                    begin
                        if (sts.count_zero)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = uapq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctl.walk_start_scan = 1'b1;
                            state_next          = S_SCAN;
                        end
                    end
                    uapq_pkg::CMD_MODIFY:
                    begin
                        if (sts.count_zero)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = uapq_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            ctl.walk_start_scan = 1'b1;
                            state_next          = S_SCAN;
                        end
                    end
                    uapq_pkg::CMD_CLEAR:
                    begin
                        ctl.do_clear = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (!sts.walk_done)
                begin
                    ctl.walk_scan = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                    case (sts.cmd)
                        uapq_pkg::CMD_MODIFY:
                        begin
                            if (sts.found)
                            begin
                                ctl.do_modify = 1'b1;
                            end
                            else
                            begin
                                ctl.set_status  = 1'b1;
                                ctl.status_code = uapq_pkg::ST_NOTFOUND;
                            end
                        end
                        uapq_pkg::CMD_PEEK:
                        begin
                            ctl.take_best = 1'b1;
                        end
                        uapq_pkg::CMD_EXTRACT:
                        begin
                            ctl.take_best = 1'b1;
                            if (sts.shift_needed)
                            begin
                                ctl.walk_start_shift = 1'b1;
                                state_next           = S_SHIFT;
                            end
                            else
                            begin
                                ctl.dec_count = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (!sts.walk_done)
                begin
                    ctl.walk_shift = 1'b1;
                end
                else
                begin
                    ctl.dec_count = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // A result is only loaded when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n) ctl.finish |-> sts.out_free)
        else $error("result loaded while output register busy");

    // Removing an entry requires a nonempty queue
    assert property (@(posedge clk) disable iff (!rst_n) ctl.dec_count |-> !sts.count_zero)
        else $error("count decrement on empty queue");

    // Only search commands walk the store
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.walk_scan |-> (sts.cmd == uapq_pkg::CMD_EXTRACT ||
                           sts.cmd == uapq_pkg::CMD_PEEK ||
                           sts.cmd == uapq_pkg::CMD_MODIFY))
        else $error("scan running for a non-search command");
`endif

endmodule

`default_nettype wire

FILE: rtl/uapq_datapath.sv
// Entry store, count, scan/shift walker, max and match trackers, output register.
// Depends on uapq_pkg; commanded by uapq_ctrl.
`default_nettype none

module uapq_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire uapq_pkg::uapq_ctrl_t               ctl,
    output uapq_pkg::uapq_stat_t                    sts,
    input  wire logic [uapq_pkg::CMD_W-1:0]         cmd,
    input  wire logic signed [uapq_pkg::VAL_W-1:0]  item_value,
    input  wire logic signed [uapq_pkg::VAL_W-1:0]  item_priority,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic signed [uapq_pkg::VAL_W-1:0]       out_value,
    output logic [uapq_pkg::STAT_W-1:0]             status,
    output logic [uapq_pkg::OCC_W-1:0]              occupancy
);

    localparam int IDX_W  = uapq_pkg::IDX_W;
    localparam int CNT_W  = uapq_pkg::CNT_W;
    localparam int VAL_W  = uapq_pkg::VAL_W;
    localparam int WORD_W = uapq_pkg::WORD_W;

    // Entry store: {value, priority} per word
    logic [WORD_W-1:0] mem [uapq_pkg::CAPACITY];
    logic [WORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // Control registers
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] rd_ptr_next;
    logic             rd_pend_reg;
    logic             rd_pend_next;
    logic             found_reg;
    logic             found_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // Payload registers
    logic [uapq_pkg::CMD_W-1:0]   cmd_reg;
    logic signed [VAL_W-1:0]      val_reg;
    logic signed [VAL_W-1:0]      pri_reg;
    logic [IDX_W-1:0]             rd_idx_reg;
    logic signed [VAL_W-1:0]      best_val_reg;
    logic signed [VAL_W-1:0]      best_pri_reg;
    logic [IDX_W-1:0]             best_idx_reg;
    logic [IDX_W-1:0]             match_idx_reg;
    logic signed [VAL_W-1:0]      res_value_reg;
    logic [uapq_pkg::STAT_W-1:0]  res_status_reg;
    logic signed [VAL_W-1:0]      out_value_reg;
    logic [uapq_pkg::STAT_W-1:0]  out_status_reg;
    logic [uapq_pkg::OCC_W-1:0]   out_occ_reg;

    logic                         walk_active;
    logic                         issue;
    logic                         scan_step;
    logic signed [VAL_W-1:0]      rd_val;
    logic signed [VAL_W-1:0]      rd_pri;
    logic                         take_new_best;
    logic                         new_match;

    // Walker and write port selection
    always_comb
    begin
        walk_active   = ctl.walk_scan || ctl.walk_shift;
        issue         = walk_active && (rd_ptr_reg < count_reg);
        rd_addr       = rd_ptr_reg[IDX_W-1:0];
        scan_step     = ctl.walk_scan && rd_pend_reg;
        rd_val        = rd_data_reg[WORD_W-1:VAL_W];
        rd_pri        = rd_data_reg[VAL_W-1:0];
        take_new_best = (rd_idx_reg == '0) || (rd_pri > best_pri_reg);
        new_match     = !found_reg && (rd_val == val_reg);

        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = {val_reg, pri_reg};
        if (ctl.do_insert)
        begin
            mem_we = 1'b1;
        end
        else if (ctl.do_modify)
        begin
            mem_we    = 1'b1;
            mem_waddr = match_idx_reg;
        end
        else if (ctl.walk_shift && rd_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_reg - IDX_W'(1);
            mem_wdata = rd_data_reg;
        end
    end

    // Next values of control registers
    always_comb
    begin
        count_next = count_reg;
        if (ctl.do_clear)
        begin
            count_next = '0;
        end
        else if (ctl.do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.dec_count)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        rd_ptr_next = rd_ptr_reg;
        if (ctl.walk_start_scan)
        begin
            rd_ptr_next = '0;
        end
        else if (ctl.walk_start_shift)
        begin
            rd_ptr_next = CNT_W'(best_idx_reg) + CNT_W'(1);
        end
        else if (issue)
        begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
        end
        rd_pend_next = issue;

        found_next = found_reg;
        if (ctl.walk_start_scan)
        begin
            found_next = 1'b0;
        end
        else if (scan_step && new_match)
        begin
            found_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg        <= cmd;
            val_reg        <= item_value;
            pri_reg        <= item_priority;
            res_value_reg  <= uapq_pkg::NONE_VALUE;
            res_status_reg <= uapq_pkg::ST_OK;
        end
        if (ctl.take_best)
        begin
            res_value_reg <= best_val_reg;
        end
        if (ctl.set_status)
        begin
            res_status_reg <= ctl.status_code;
        end
        if (issue)
        begin
            rd_idx_reg <= rd_ptr_reg[IDX_W-1:0];
        end
        // Earliest strictly greater priority wins
        if (scan_step && take_new_best)
        begin
            best_val_reg <= rd_val;
            best_pri_reg <= rd_pri;
            best_idx_reg <= rd_idx_reg;
        end
        if (scan_step && new_match)
        begin
            match_idx_reg <= rd_idx_reg;
        end
        if (ctl.finish)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_occ_reg    <= uapq_pkg::OCC_W'(count_reg);
        end
    end

    // Status back to the controller
    always_comb
    begin
        sts.cmd          = cmd_reg;
        sts.count_zero   = (count_reg == '0);
        sts.count_full   = (count_reg == CNT_W'(uapq_pkg::CAPACITY));
        sts.walk_done    = (rd_ptr_reg >= count_reg) && !rd_pend_reg;
        sts.found        = found_reg;
        sts.shift_needed = (CNT_W'(best_idx_reg) + CNT_W'(1)) < count_reg;
        sts.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = out_status_reg;
    assign occupancy = out_occ_reg;

`ifndef SYNTH
    // Occupancy never exceeds the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(uapq_pkg::CAPACITY))
        else $error("entry count above capacity");

    // Every word read during a walk lies inside the live entries
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (CNT_W'(rd_idx_reg) < count_reg))
        else $error("walker read beyond live entries");

    // An insert grows the queue by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow count by one");
`endif

endmodule

`default_nettype wire

FILE: rtl/unsorted_array_priority_queue_unit.sv
// Unsorted-array max priority queue: top level joining controller and datapath.
// Depends on uapq_pkg, uapq_req_if, uapq_rsp_if, uapq_ctrl, uapq_datapath.
//
// Usage:
//   req carries one command word (cmd, item_value, item_priority); rsp returns
//   exactly one result word (out_value, status, occupancy) per command, in order.
//   Commands are taken one at a time. Entries live in a single-port-read memory
//   that is walked one entry per cycle. How each command uses the store:
//     insert, clear, unused codes, empty extract/peek/modify key: no walk.
//     peek, modify key: a scan over the N entries held.
//     extract: a scan as for peek, then, when entries follow the removed one at
//     position m (from zero), a shift walk moving them down to close the gap.
//   The next command is accepted the cycle after the result enters the output
//   register, even if that result has not been taken yet. If rsp stalls with a
//   result still held, the following result waits in the datapath and req
//   stays not ready until the output register frees.
//   Reset (rst_n low, asynchronous) empties the queue and drops any pending
//   result; entry contents are not cleared and need no clearing pass.
`default_nettype none

module unsorted_array_priority_queue_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    uapq_req_if.sink   req,
    uapq_rsp_if.source rsp
);

    uapq_pkg::uapq_ctrl_t ctl;
    uapq_pkg::uapq_stat_t sts;
    logic                 req_ready;

    // Sequencer
    uapq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Store and result path
    uapq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cmd           (req.cmd),
        .item_value    (req.item_value),
        .item_priority (req.item_priority),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .out_value     (rsp.out_value),
        .status        (rsp.status),
        .occupancy     (rsp.occupancy)
    );

    assign req.ready = req_ready;

endmodule

`default_nettype wire

FILE: tb/tb_unsorted_array_priority_queue_unit.sv
// Testbench for the unsorted-array max priority queue: sends command words,
// checks every result word against a shadow queue kept in the testbench.
// Depends on uapq_pkg, uapq_req_if, uapq_rsp_if and the RTL top level.

module tb_unsorted_array_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import uapq_pkg::*;

    // Command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_TICKS = 2 * CAPACITY + 20;
    localparam int DRAIN_LIMIT  = 200000;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [STAT_W-1:0]       status;
        logic [OCC_W-1:0]        occupancy;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n;

    uapq_req_if req_ch();
    uapq_rsp_if rsp_ch();

    unsorted_array_priority_queue_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the queue, in insertion order
    logic signed [VAL_W-1:0] shadow_values[$];
    logic signed [VAL_W-1:0] shadow_priorities[$];
    queue_result_t           pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int peak_occupancy = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    always #4 clk = ~clk;

    // Work out the result of one command and update the shadow queue
    function automatic queue_result_t predict_queue_result(
        input logic [CMD_W-1:0]      cmd,
        input logic signed [VAL_W-1:0] value,
        input logic signed [VAL_W-1:0] prio
    );
        queue_result_t res;
        int best;
        int i;
        res.value  = NONE_VALUE;
        res.status = ST_OK;
        case (cmd)
            CMD_INSERT:
            begin
                if (shadow_values.size() >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    shadow_values.push_back(value);
                    shadow_priorities.push_back(prio);
                end
            end
            CMD_EXTRACT, CMD_PEEK:
            begin
                if (shadow_values.size() == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    // strict compare keeps the earliest entry on a tie
                    best = 0;
                    for (i = 1; i < shadow_values.size(); i++)
                    begin
                        if (shadow_priorities[i] > shadow_priorities[best])
                            best = i;
                    end
                    res.value = shadow_values[best];
                    if (cmd == CMD_EXTRACT)
                    begin
                        shadow_values.delete(best);
                        shadow_priorities.delete(best);
                    end
                end
            end
            CMD_MODIFY:
            begin
                res.status = ST_NOTFOUND;
                for (i = 0; i < shadow_values.size(); i++)
                begin
                    if (shadow_values[i] == value)
                    begin
                        shadow_priorities[i] = prio;
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            CMD_CLEAR:
            begin
                shadow_values.delete();
                shadow_priorities.delete();
            end
            default:
            begin
            end
        endcase
        res.occupancy = OCC_W'(shadow_values.size());
        return res;
    endfunction

    // Field value: small pool for ties and matches, held values, random, extremes
    function automatic logic signed [VAL_W-1:0] pick_field(input bit reuse_held);
        case ($urandom_range(3))
            0: return VAL_W'($urandom_range(7)) - VAL_W'(4);
            1:
            begin
                if (reuse_held && shadow_values.size() != 0)
                    return shadow_values[$urandom_range(shadow_values.size() - 1)];
                return $urandom;
            end
            2: return $urandom;
            default:
            begin
                case ($urandom_range(3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, what);
    endtask

    // Send one command word; entered and left at a falling edge
    task automatic send_word(
        input logic [CMD_W-1:0]        cmd,
        input logic signed [VAL_W-1:0] value,
        input logic signed [VAL_W-1:0] prio
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.item_value    <= value;
        req_ch.item_priority <= prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_queue_result(cmd, value, prio));
        words_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every result word has come back
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Receiver stalls at random
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        queue_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result word: value %h status %0d occupancy %0d",
                                       rsp_ch.out_value, rsp_ch.status, rsp_ch.occupancy));
            else
            begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (int'(want.occupancy) > peak_occupancy)
                    peak_occupancy = want.occupancy;
                if (rsp_ch.out_value !== want.value || rsp_ch.status !== want.status ||
                    rsp_ch.occupancy !== want.occupancy)
                    note_failure($sformatf(
                        "mismatch: expected value %h status %0d occupancy %0d, got %h %0d %0d",
                        want.value, want.status, want.occupancy,
                        rsp_ch.out_value, rsp_ch.status, rsp_ch.occupancy));
            end
        end
    end

    // Every command but insert on an empty queue, unused codes included
    task automatic test_empty_queue();
        send_word(CMD_EXTRACT, VAL_MAX, VAL_MIN);
        send_word(CMD_PEEK, VAL_MIN, VAL_MAX);
        send_word(CMD_MODIFY, VAL_MIN, VAL_MAX);
        send_word(CMD_CLEAR, '1, '1);
        send_word(CMD_SPARE_A, '1, '0);
        send_word(CMD_SPARE_B, '0, '1);
        send_word(CMD_SPARE_C, VAL_MAX, VAL_MAX);
    endtask

    // Extreme values and priorities, priority ties, modify hits and misses
    task automatic test_extreme_fields();
        send_word(CMD_INSERT, VAL_MIN, VAL_MIN);
        send_word(CMD_INSERT, VAL_MAX, VAL_MAX);
        send_word(CMD_INSERT, '0, '1);
        send_word(CMD_INSERT, '1, VAL_MAX);
        send_word(CMD_PEEK, '0, '0);
        send_word(CMD_MODIFY, 32'sd5, '0);
        send_word(CMD_MODIFY, VAL_MAX, VAL_MIN);
        send_word(CMD_INSERT, '0, 32'sd100);
        send_word(CMD_MODIFY, '0, 32'sd200);
        repeat (5)
            send_word(CMD_EXTRACT, $urandom, $urandom);
        send_word(CMD_PEEK, $urandom, $urandom);
    endtask

    // Fill to capacity, overflow, then free one slot and refill
    task automatic test_full_queue();
        send_word(CMD_CLEAR, $urandom, $urandom);
        while (shadow_values.size() < CAPACITY)
            send_word(CMD_INSERT, pick_field(1'b1), pick_field(1'b0));
        send_word(CMD_INSERT, $urandom, $urandom);
        send_word(CMD_INSERT, VAL_MAX, VAL_MAX);
        send_word(CMD_MODIFY, shadow_values[CAPACITY - 1], VAL_MAX);
        send_word(CMD_PEEK, $urandom, $urandom);
        send_word(CMD_EXTRACT, $urandom, $urandom);
        send_word(CMD_INSERT, pick_field(1'b1), pick_field(1'b0));
        send_word(CMD_INSERT, $urandom, $urandom);
    endtask

    // Random commands; the mix swings between growing and shrinking the queue
    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        bit filling;
        int n;
        int roll;
        logic [CMD_W-1:0] cmd;
        logic signed [VAL_W-1:0] value;
        wait_for_results();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        filling = 1'b1;
        for (n = 0; n < count; n++)
        begin
            if (shadow_values.size() >= CAPACITY - $urandom_range(4))
                filling = 1'b0;
            else if (shadow_values.size() <= $urandom_range(2))
                filling = 1'b1;
            else if ($urandom_range(49) == 0)
                filling = ~filling;

            roll = $urandom_range(99);
            if (roll < (filling ? 60 : 22))
                cmd = CMD_INSERT;
            else if (roll < 72)
                cmd = CMD_EXTRACT;
            else if (roll < 82)
                cmd = CMD_PEEK;
            else if (roll < 95)
                cmd = CMD_MODIFY;
            else if (roll < 97)
                cmd = CMD_CLEAR;
            else
            begin
                case ($urandom_range(2))
                    0: cmd = CMD_SPARE_A;
                    1: cmd = CMD_SPARE_B;
                    default: cmd = CMD_SPARE_C;
                endcase
            end

            // modify mostly targets a held value so that it hits
            if (cmd == CMD_MODIFY && shadow_values.size() != 0 && $urandom_range(9) < 7)
                value = shadow_values[$urandom_range(shadow_values.size() - 1)];
            else if (cmd == CMD_INSERT || cmd == CMD_MODIFY)
                value = pick_field(1'b1);
            else
                value = $urandom;
            send_word(cmd, value, pick_field(1'b0));

            // occasional pause until the block has answered everything
            if ($urandom_range(99) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin : run_tests
        int ticks;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_INSERT;
        req_ch.item_value    = '0;
        req_ch.item_priority = '0;
        rsp_ch.ready         = 1'b0;
        rst_n                = 1'b0;
        send_idle_pct        = 17;
        recv_idle_pct        = 65;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_queue();
        test_extreme_fields();
        test_full_queue();
        test_random_traffic(290, 17, 65);
        test_random_traffic(290, 65, 17);
        test_random_traffic(290, 0, 0);

        // drain, then let the block settle
        req_ch.valid <= 1'b0;
        ticks = 0;
        while (pending_results.size() != 0 && ticks < DRAIN_LIMIT)
        begin
            @(negedge clk);
            ticks++;
        end
        repeat (SETTLE_TICKS)
            @(negedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d result words never arrived", pending_results.size()));

        $display("Sent %0d commands, checked %0d results (ok %0d, empty %0d, full %0d, missing key %0d).",
                 words_sent, results_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_FULL], status_seen[ST_NOTFOUND]);
        $display("Peak occupancy %0d of %0d, %0d failures.", peak_occupancy, CAPACITY, fail_count);
        if (fail_count == 0)
            $display("tb_unsorted_array_priority_queue_unit passed");
        else
            $display("tb_unsorted_array_priority_queue_unit failed");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #20_000_000;
        $display("tb_unsorted_array_priority_queue_unit failed");
        $finish;
    end

endmodule

FILE: unsorted_array_priority_queue_unit.f
rtl/uapq_pkg.sv
rtl/uapq_req_if.sv
rtl/uapq_rsp_if.sv
rtl/uapq_ctrl.sv
rtl/uapq_datapath.sv
rtl/unsorted_array_priority_queue_unit.sv
tb/tb_unsorted_array_priority_queue_unit.sv
